>>> src/rrqq_pkg.sv
// ============================================================================
// rrqq_pkg
// Types and constants shared by the round-robin quantum queue modules.
// ============================================================================
package rrqq_pkg;

    // Field widths fixed by the transaction format
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int JOBCNT_W  = 5;

    // Quantum after reset
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd20;

    // Item kind codes
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXECUTE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FINISHED = 3'd2,
        ST_REQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // Input transaction
    typedef struct packed {
        logic               kind;
        logic [BURST_W-1:0] burst;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        t_status             status;
        logic [BURST_W-1:0]  front_value;
        logic [BURST_W-1:0]  rear_value;
        logic [JOBCNT_W-1:0] job_count;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic    push_in;   // append the incoming burst at the rear
        logic    pop;       // remove the front job, charge one quantum
        logic    settle;    // finish or requeue the popped job
        logic    load_out;  // capture the result transaction
        t_status status;    // status carried by the captured result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic requeue;      // popped job still has time left
    } t_dp_sts;

endpackage

>>> src/round_robin_quantum_queue_top.sv
// Insert and rejected or empty transactions: result valid is raised after the result state.
// Execute on a nonempty queue: the settle state comes before the result state; settle
// waits on the registered job memory read of the next front entry.
// A new transaction is not taken until the controller is back in the idle state.
// Reset clears pointers, occupancy and result valid, and loads quantum with 20;
// the job memory is not cleared.
// ============================================================================
// round_robin_quantum_queue_top
// Round-robin job queue that charges the front job one time quantum per execute
// and requeues it at the rear until its burst is used up.
// ============================================================================
module round_robin_quantum_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rrqq_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rrqq_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [rrqq_pkg::QUANTUM_W-1:0] i_cfg_data
);

    rrqq_pkg::t_dp_cmd cmd;
    rrqq_pkg::t_dp_sts sts;

    // Sequencer
    rrqq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_in_item.kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Queue storage and arithmetic
    rrqq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_burst    (i_in_item.burst),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

>>> src/rrqq_datapath.sv
// ============================================================================
// rrqq_datapath
// Job memory, queue pointers, occupancy, cached front and rear values,
// quantum register, quantum subtract and the result register.
// ============================================================================
module rrqq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrqq_pkg::t_dp_cmd                   i_cmd,
    output rrqq_pkg::t_dp_sts                   o_sts,
    input  logic [rrqq_pkg::BURST_W-1:0]        i_burst,
    input  logic                                i_cfg_we,
    input  logic [rrqq_pkg::QUANTUM_W-1:0]      i_cfg_data,
    output rrqq_pkg::t_out_item                 o_out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BW    = rrqq_pkg::BURST_W;
    localparam int JW    = rrqq_pkg::JOBCNT_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Job memory
    logic [BW-1:0] r_mem [QUEUE_DEPTH];
    logic [BW-1:0] r_rd_data;

    // Control state
    logic [PTR_W-1:0] r_front_ptr, n_front_ptr;
    logic [PTR_W-1:0] r_rear_ptr,  n_rear_ptr;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [rrqq_pkg::QUANTUM_W-1:0] r_quantum;

    // Payload state
    logic [BW-1:0] r_front_val, n_front_val;
    logic [BW-1:0] r_rear_val,  n_rear_val;
    logic [BW-1:0] r_diff;
    logic          r_requeue;
    rrqq_pkg::t_out_item r_out_item;

    logic          wr_en;
    logic [BW-1:0] wr_data;
    logic [PTR_W-1:0] front_next;
    logic [PTR_W-1:0] rear_next;
    logic             cnt_zero;
    logic [CNT_W+JW-1:0] cnt_ext;

    // Pointer wrap
    assign front_next = (r_front_ptr == PTR_LAST) ? '0 : r_front_ptr + PTR_W'(1);
    assign rear_next  = (r_rear_ptr  == PTR_LAST) ? '0 : r_rear_ptr  + PTR_W'(1);
    assign cnt_zero   = (r_count == '0);

    // Status to controller
    assign o_sts.full    = (r_count == CNT_FULL);
    assign o_sts.empty   = cnt_zero;
    assign o_sts.requeue = r_requeue;

    // Rear write: new job or requeued remainder
    assign wr_en   = i_cmd.push_in || (i_cmd.settle && r_requeue);
    assign wr_data = i_cmd.push_in ? i_burst : r_diff;

    // Memory write port and registered read of the next front entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_rear_ptr] <= wr_data;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[front_next];
        end
    end

    // Next pointers, count and cached end values
    always_comb begin
        n_front_ptr = r_front_ptr;
        n_rear_ptr  = r_rear_ptr;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_rear_val  = r_rear_val;
        if (wr_en) begin
            n_rear_ptr = rear_next;
            n_count    = r_count + CNT_W'(1);
            n_rear_val = wr_data;
        end
        if (i_cmd.push_in && cnt_zero) begin
            n_front_val = i_burst;
        end
        if (i_cmd.pop) begin
            n_front_ptr = front_next;
            n_count     = r_count - CNT_W'(1);
        end
        if (i_cmd.settle) begin
            if (!cnt_zero) begin
                n_front_val = r_rd_data;
            end else if (r_requeue) begin
                n_front_val = r_diff;
            end
        end
    end

    // Hold control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_ptr <= '0;
            r_rear_ptr  <= '0;
            r_count     <= '0;
            r_quantum   <= rrqq_pkg::QUANTUM_RESET;
        end else begin
            r_front_ptr <= n_front_ptr;
            r_rear_ptr  <= n_rear_ptr;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    // Charge one quantum to the popped job
    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_rear_val  <= n_rear_val;
        if (i_cmd.pop) begin
            r_requeue <= (r_front_val > r_quantum);
            r_diff    <= r_front_val - r_quantum;
        end
    end

    // Capture the result transaction
    assign cnt_ext = {{JW{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.status      <= i_cmd.status;
            r_out_item.front_value <= cnt_zero ? '0 : r_front_val;
            r_out_item.rear_value  <= cnt_zero ? '0 : r_rear_val;
            r_out_item.job_count   <= cnt_ext[JW-1:0];
        end
    end

    assign o_out_item = r_out_item;

    // Occupancy never exceeds the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("occupancy above queue depth");

    // A new job raises the occupancy by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_in |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not raise occupancy");

    // Pointers stay consistent with occupancy
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt_zero || o_sts.full) |-> r_front_ptr == r_rear_ptr)
        else $error("pointers disagree with occupancy");

endmodule

>>> src/rrqq_ctrl.sv
// ============================================================================
// rrqq_ctrl
// Sequencer for the queue: handshakes, operation decode and result timing.
// ============================================================================
module rrqq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rrqq_pkg::t_dp_cmd o_cmd,
    input  rrqq_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETTLE,
        S_RESULT
    } t_state;

    t_state            r_state, n_state;
    rrqq_pkg::t_status r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    rrqq_pkg::t_dp_cmd cmd;

    // Take a transaction only when idle and the result register frees up
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Decode commands and next state
    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        cmd.push_in   = 1'b0;
        cmd.pop       = 1'b0;
        cmd.settle    = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.status    = r_status;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESULT;
                    if (i_kind == rrqq_pkg::KIND_INSERT) begin
                        if (i_sts.full) begin
                            n_status = rrqq_pkg::ST_REJECTED;
                        end else begin
                            cmd.push_in = 1'b1;
                            n_status    = rrqq_pkg::ST_INSERTED;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            n_status = rrqq_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop = 1'b1;
                            n_state = S_SETTLE;
                        end
                    end
                end
            end
            S_SETTLE: begin
                cmd.settle = 1'b1;
                n_status   = i_sts.requeue ? rrqq_pkg::ST_REQUEUED : rrqq_pkg::ST_FINISHED;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                cmd.load_out = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= rrqq_pkg::ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    // The result register is free whenever a result is captured
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> !r_out_valid)
        else $error("result captured over a pending transaction");

    // Settle only follows a pop of a nonempty queue
    a_settle_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETTLE) |-> $past(cmd.pop))
        else $error("settle without a preceding pop");

    // A pop never hits an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> (!i_sts.empty && accept))
        else $error("pop on empty queue");

endmodule
